@@ src/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define DCRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property that must never hold, same clocking and reset.
`define DCRC_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  `DCRC_ASSERT(lbl, clk, rstn, !(prop), msg)

`endif

@@ src/dcrc_pkg.sv @@
package dcrc_pkg;

  localparam logic [15:0] CrcPoly = 16'h8005;
  localparam logic [15:0] CrcInit = 16'h0000;

  localparam int InDataW  = 24;  // data_byte + expected_crc
  localparam int OutDataW = 40;  // crc_plain + crc_reflected + crc_hit, byte padded

  typedef struct packed {
    logic [15:0] expected_crc;
    logic        last_byte;
    logic [7:0]  data_byte;
  } dcrc_item_t;

  // One byte through the MSB-first shift register, unrolled.
  function automatic logic [15:0] crc_byte(input logic [15:0] rem, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = rem;
    for (int i = 0; i < 8; i++) begin
      fb = r[15] ^ b[7-i];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [15:0] mirror16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15-i];
    end
    return r;
  endfunction

endpackage

@@ src/dual_order_crc16_check.sv @@
// Channel   Dir  Signals                      Payload
// s_axis    in   tvalid tready tdata tlast    tdata: data_byte, expected_crc; tlast: last_byte
// m_axis    out  tvalid tready tdata          tdata: crc_plain, crc_reflected, crc_hit
//
// One byte per cycle sustained while no result is stalled.
// Input register feeds the unrolled byte-wide CRC update and the result register.
// rst_ni is asynchronous, active low; both CRC registers clear to zero.
// A last byte waits in the input register while a result is stalled; other bytes
// keep flowing.
module dual_order_crc16_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] data_byte, [23:8] expected_crc
  input  logic [dcrc_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                             s_axis_tlast,   // last_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] crc_plain, [31:16] crc_reflected, [32] crc_hit, [39:33] zero
  output logic [dcrc_pkg::OutDataW-1:0]    m_axis_tdata
);
  import dcrc_pkg::*;

  logic       item_valid;
  logic       item_ready;
  dcrc_item_t item;

  dcrc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  dcrc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

@@ src/dcrc_in_stage.sv @@
module dcrc_in_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dcrc_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             item_valid_o,
  output dcrc_pkg::dcrc_item_t             item_o,
  input  logic                             item_ready_i
);
  import dcrc_pkg::*;

  logic       valid_q;
  dcrc_item_t item_q;

  // Register refills in the same cycle the core drains it.
  assign s_axis_tready = !valid_q || item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.data_byte    <= s_axis_tdata[7:0];
      item_q.expected_crc <= s_axis_tdata[23:8];
      item_q.last_byte    <= s_axis_tlast;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ src/dcrc_core.sv @@
module dcrc_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             item_valid_i,
  input  dcrc_pkg::dcrc_item_t             item_i,
  output logic                             item_ready_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [dcrc_pkg::OutDataW-1:0]    m_axis_tdata
);
  import dcrc_pkg::*;

  logic [15:0] plain_q, plain_d;
  logic [15:0] refl_q, refl_d;
  logic [15:0] refl_out;
  logic        match;
  logic        adv;
  logic        out_valid_q;
  logic [15:0] out_plain_q;
  logic [15:0] out_refl_q;
  logic        out_match_q;

  // Only a last byte needs room in the result register.
  assign item_ready_o = !item_i.last_byte || !out_valid_q || m_axis_tready;
  assign adv          = item_valid_i && item_ready_o;

  assign plain_d  = crc_byte(plain_q, item_i.data_byte);
  assign refl_d   = crc_byte(refl_q, mirror8(item_i.data_byte));
  assign refl_out = mirror16(refl_d);
  assign match    = (plain_d == item_i.expected_crc) || (refl_out == item_i.expected_crc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_q     <= CrcInit;
      refl_q      <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        if (item_i.last_byte) begin
          plain_q <= CrcInit;
          refl_q  <= CrcInit;
        end else begin
          plain_q <= plain_d;
          refl_q  <= refl_d;
        end
      end
      if (adv && item_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && item_i.last_byte) begin
      out_plain_q <= plain_d;
      out_refl_q  <= refl_out;
      out_match_q <= match;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, out_match_q, out_refl_q, out_plain_q};

endmodule

@@ src/dcrc_checker.sv @@
`include "assert_macros.svh"

module dcrc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dcrc_pkg::OutDataW-1:0]    m_axis_tdata
);

  // A stalled result stays offered and unchanged.
  `DCRC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // A fresh result follows a last-byte request through the input and result registers.
  `DCRC_ASSERT(a_out_origin, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "result without a last byte")

  // Input only backs up behind a stalled result.
  `DCRC_ASSERT_NEVER(a_in_stall, clk_i, rst_ni, !s_axis_tready && !(m_axis_tvalid && !m_axis_tready), "input stalled with output free")

  // Padding bits of the result stay zero.
  `DCRC_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[39:33] == 7'b0000000, "nonzero padding")

endmodule

bind dual_order_crc16_check dcrc_checker u_dcrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

@@ bench/dual_order_crc16_check_test.sv @@
`timescale 1ns / 1ps

module dual_order_crc16_check_test;
  import dcrc_pkg::*;

  localparam int HoldCycles = 300;
  localparam int SettleCycles = 10;
  localparam int TargetBytes = 1700;

  typedef struct packed {
    logic [15:0] plain;
    logic [15:0] refl;
    logic        match;
  } crc_result_t;

  // Tracks both running CRCs over accepted bytes and the results still owed.
  class crc_scoreboard;
    logic [15:0] plain_rem;
    logic [15:0] refl_rem;
    crc_result_t owed_q[$];
    int          errors;

    function new();
      plain_rem = CrcInit;
      refl_rem  = CrcInit;
      errors    = 0;
    endfunction

    function logic [15:0] shift_in(logic [15:0] r, logic [7:0] b);
      for (int k = 7; k >= 0; k--) begin
        r = {r[14:0], 1'b0} ^ ({16{r[15] ^ b[k]}} & CrcPoly);
      end
      return r;
    endfunction

    function logic [7:0] swap8(logic [7:0] v);
      logic [7:0] o;
      for (int k = 0; k < 8; k++) o[7-k] = v[k];
      return o;
    endfunction

    function logic [15:0] swap16(logic [15:0] v);
      logic [15:0] o;
      for (int k = 0; k < 16; k++) o[15-k] = v[k];
      return o;
    endfunction

    // CRCs a whole block would give, without touching the running state.
    function void block_crc(input logic [7:0] blk[$], output logic [15:0] p,
                            output logic [15:0] r);
      logic [15:0] rr;
      p  = CrcInit;
      rr = CrcInit;
      foreach (blk[k]) begin
        p  = shift_in(p, blk[k]);
        rr = shift_in(rr, swap8(blk[k]));
      end
      r = swap16(rr);
    endfunction

    function void note_byte(logic [7:0] d, logic last, logic [15:0] exp_crc);
      crc_result_t res;
      plain_rem = shift_in(plain_rem, d);
      refl_rem  = shift_in(refl_rem, swap8(d));
      if (last) begin
        res.plain = plain_rem;
        res.refl  = swap16(refl_rem);
        res.match = (res.plain == exp_crc) || (res.refl == exp_crc);
        owed_q.push_back(res);
        plain_rem = CrcInit;
        refl_rem  = CrcInit;
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] t);
      crc_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("unexpected result", t[31:0], 32'h0);
        return;
      end
      want = owed_q.pop_front();
      if (t[15:0] !== want.plain) begin
        report_mismatch("crc_plain", 32'(t[15:0]), 32'(want.plain));
      end
      if (t[31:16] !== want.refl) begin
        report_mismatch("crc_reflected", 32'(t[31:16]), 32'(want.refl));
      end
      if (t[32] !== want.match) begin
        report_mismatch("crc_hit", 32'(t[32]), 32'(want.match));
      end
      if (t[39:33] !== 7'h0) begin
        report_mismatch("tdata padding", 32'(t[39:33]), 32'h0);
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  crc_scoreboard board = new();
  bit calm;      // both sides run without gaps while set
  bit hold_req;  // receiver holds off for a long stretch

  dual_order_crc16_check u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function int draw_gap();
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task send_byte(logic [7:0] d, logic last, logic [15:0] exp_crc);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {exp_crc, d};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_byte(d, last, exp_crc);
  endtask

  // Non-last bytes carry random expected_crc, which the block must ignore.
  task send_block(logic [7:0] blk[$], logic [15:0] exp_crc);
    foreach (blk[k]) begin
      if (k == blk.size() - 1) send_byte(blk[k], 1'b1, exp_crc);
      else send_byte(blk[k], 1'b0, 16'($urandom));
    end
  endtask

  // receiver
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata);
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [7:0]  blk[$];
    logic [15:0] p;
    logic [15:0] r;
    logic [15:0] exp_crc;
    int          sent;
    int          nblk;
    int          len;
    int          pick;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-byte blocks at the byte extremes
    blk = '{8'h00};
    send_block(blk, 16'h0000);
    blk = '{8'hFF};
    send_block(blk, 16'hFFFF);
    // standard check string, BUYPASS check value
    blk = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
    send_block(blk, 16'hFEE8);
    // same string, ARC check value
    send_block(blk, 16'hBB3D);
    blk = '{8'hFF, 8'h80};
    board.block_crc(blk, p, r);
    send_block(blk, r);
    blk = '{8'h01};
    board.block_crc(blk, p, r);
    send_block(blk, ~p);

    sent = 0;
    nblk = 0;
    while (sent < TargetBytes) begin
      if (nblk % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      // long receiver hold-off with the sender flat out
      if (nblk == 60) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (nblk >= 60 && nblk < 100) len = $urandom_range(1, 3);
      else if (pick < 2) len = 1;
      else if (pick < 9) len = $urandom_range(1, 8);
      else len = $urandom_range(9, 40);
      blk.delete();
      repeat (len) blk.push_back(8'($urandom));
      board.block_crc(blk, p, r);
      case ($urandom_range(0, 3))
        0: exp_crc = p;
        1: exp_crc = r;
        2: exp_crc = 16'($urandom);
        default: exp_crc = p ^ (16'h1 << $urandom_range(0, 15));
      endcase
      send_block(blk, exp_crc);
      sent += len;
      nblk++;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (board.owed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
